// ----- src/pdq_pkg.sv -----
// ----------------------------------------------------------------------------
// pdq_pkg
// Shared operation and status codes plus controller/datapath command types.
// ----------------------------------------------------------------------------
package pdq_pkg;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_INSERT     = 3'd4;
  localparam logic [2:0] OP_REMOVE     = 3'd5;
  localparam logic [2:0] OP_CLEAR      = 3'd6;
  localparam logic [2:0] OP_REVERSE    = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // datapath command codes
  localparam logic [2:0] DC_IDLE   = 3'd0;
  localparam logic [2:0] DC_LOAD   = 3'd1;  // latch request, start
  localparam logic [2:0] DC_EXEC   = 3'd2;  // end ops, clear, reverse, refusal
  localparam logic [2:0] DC_RDSH   = 3'd3;  // issue shift read
  localparam logic [2:0] DC_WRSH   = 3'd4;  // write shifted word
  localparam logic [2:0] DC_FINAL  = 3'd5;  // finish insert/remove
  localparam logic [2:0] DC_RDFB   = 3'd6;  // read front
  localparam logic [2:0] DC_RDBK   = 3'd7;  // read back

  typedef struct packed {
    logic [2:0] cmd;
  } pdq_cmd_t;

  typedef struct packed {
    logic refuse;    // request refused or pop from empty
    logic shifting;  // insert/remove with words left to move
    logic is_end_op; // handled fully in EXEC
  } pdq_stat_t;

endpackage

// ----- src/positional_deque_store_top.sv -----
// ----------------------------------------------------------------------------
// positional_deque_store_top
// Double-ended queue with positional insert and remove over a circular store.
// ----------------------------------------------------------------------------
//  channel | ports                                         | direction
//  input   | in_valid in_stall in_mode in_value_in in_position | in
//  result  | out_valid out_stall out_value_out out_status  | out
//          | out_length out_front_value out_back_value     |
//
// End operations, clear, reverse and refusals pass through accept, execute,
// front read and back read before the result is presented.
// Insert and remove move one word at a time, a read then a write, through
// the single store port before the final step and the front and back reads.
// Synchronous active-low reset empties the queue; the store is not cleared.
// One transaction at a time; a stalled result holds and blocks new input.
module positional_deque_store_top
  import pdq_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_value_in,
  input  logic [6:0]  in_position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_value_out,
  output logic [1:0]  out_status,
  output logic [6:0]  out_length,
  output logic [31:0] out_front_value,
  output logic [31:0] out_back_value
);

  pdq_cmd_t  cmd;
  pdq_stat_t stat;

  pdq_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .stat, .cmd
  );

  pdq_dp #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_mode, .in_value_in, .in_position,
    .out_value_out, .out_status, .out_length, .out_front_value, .out_back_value
  );

endmodule

// ----- src/pdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// pdq_ctrl
// Sequencer: accept, execute or shift, read front and back, present result.
// ----------------------------------------------------------------------------
module pdq_ctrl
  import pdq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  pdq_stat_t stat,
  output pdq_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_FR   = 3'd5;
  localparam logic [2:0] S_BK   = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_r, state_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd.cmd   = DC_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cmd   = DC_LOAD;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.refuse || stat.is_end_op) begin
          cmd.cmd   = DC_EXEC;
          state_nxt = S_FR;
        end else if (stat.shifting) begin
          cmd.cmd   = DC_RDSH;
          state_nxt = S_WR;
        end else begin
          cmd.cmd   = DC_FINAL;
          state_nxt = S_FR;
        end
      end
      S_RD: begin
        if (stat.shifting) begin
          cmd.cmd   = DC_RDSH;
          state_nxt = S_WR;
        end else begin
          cmd.cmd   = DC_FINAL;
          state_nxt = S_FR;
        end
      end
      S_WR: begin
        cmd.cmd   = DC_WRSH;
        state_nxt = S_RD;
      end
      S_FIN: begin
        state_nxt = S_FR;
      end
      S_FR: begin
        cmd.cmd   = DC_RDFB;
        state_nxt = S_BK;
      end
      S_BK: begin
        cmd.cmd   = DC_RDBK;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ----- src/pdq_dp.sv -----
// ----------------------------------------------------------------------------
// pdq_dp
// Circular word store with head slot, direction flag and shift engine.
// ----------------------------------------------------------------------------
module pdq_dp
  import pdq_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  pdq_cmd_t    cmd,
  output pdq_stat_t   stat,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_value_in,
  input  logic [6:0]  in_position,
  output logic [31:0] out_value_out,
  output logic [1:0]  out_status,
  output logic [6:0]  out_length,
  output logic [31:0] out_front_value,
  output logic [31:0] out_back_value
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 7) ? CW : 7;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  logic [CW-1:0] count_r;
  logic [AW-1:0] head_r;
  logic          rev_r;
  logic [2:0]    mode_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [PW-1:0] pos_r;
  logic [CW-1:0] idx_r;   // current logical index of the shift
  logic [DATA_WIDTH-1:0] rd_r;
  logic [31:0]   vout_r, front_r, back_r;
  logic [1:0]    st_r;

  logic [PW-1:0] cnt_w;
  assign cnt_w = PW'(count_r);

  // logical position to physical slot; i stays below 2*CAPACITY, fold it once
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic r,
                                         input logic [CW:0] i);
    logic [CW+1:0] k, s;
    k = (CW+2)'(i);
    if (k >= (CW+2)'(CAPACITY)) k = k - (CW+2)'(CAPACITY);
    if (r) s = (CW+2)'(h) + (CW+2)'(CAPACITY) - k;
    else   s = (CW+2)'(h) + k;
    if (s >= (CW+2)'(CAPACITY)) s = s - (CW+2)'(CAPACITY);
    return AW'(s);
  endfunction

  logic full, empty, ins_bad, rem_bad;
  assign full    = (count_r == CW'(CAPACITY));
  assign empty   = (count_r == '0);
  assign ins_bad = (pos_r > cnt_w);
  assign rem_bad = (pos_r >= cnt_w);

  always_comb begin
    stat.refuse    = 1'b0;
    stat.is_end_op = 1'b0;
    stat.shifting  = 1'b0;
    unique case (mode_r)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        stat.refuse = full; stat.is_end_op = 1'b1;
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        stat.refuse = empty; stat.is_end_op = 1'b1;
      end
      OP_INSERT: begin
        stat.refuse   = ins_bad || full;
        stat.shifting = (PW'(idx_r) > pos_r);
      end
      OP_REMOVE: begin
        stat.refuse   = rem_bad;
        stat.shifting = (PW'(idx_r) + PW'(1) < cnt_w);
      end
      default: stat.is_end_op = 1'b1;
    endcase
  end

  // shift source and destination
  logic [CW:0]   src_i;
  logic [AW-1:0] src_a, dst_a;
  assign src_i = (mode_r == OP_INSERT) ? ((CW+1)'(idx_r) + (CW+1)'(CAPACITY) - 1'b1)
                                       : ((CW+1)'(idx_r) + 1'b1);
  assign src_a = phys(head_r, rev_r, src_i);
  assign dst_a = phys(head_r, rev_r, (CW+1)'(idx_r));

  logic [AW-1:0] front_a, back_a;
  assign front_a = head_r;
  assign back_a  = phys(head_r, rev_r, (CW+1)'(count_r) + (CW+1)'(CAPACITY) - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      head_r  <= '0;
      rev_r   <= 1'b0;
    end else begin
      unique case (cmd.cmd)
        DC_LOAD: begin
          mode_r <= in_mode;
          val_r  <= DATA_WIDTH'(in_value_in);
          pos_r  <= PW'(in_position);
          st_r   <= ST_OK;
          idx_r  <= (in_mode == OP_INSERT) ? count_r : CW'(in_position);
          // capture the removed word before the shift overwrites it
          if (in_mode == OP_REMOVE && PW'(in_position) < cnt_w)
            vout_r <= 32'(mem[phys(head_r, rev_r, (CW+1)'(in_position))]);
          else
            vout_r <= '0;
        end
        DC_EXEC: begin
          if (stat.refuse) begin
            unique case (mode_r)
              OP_POP_FRONT, OP_POP_BACK: st_r <= ST_EMPTY;
              OP_PUSH_FRONT, OP_PUSH_BACK: st_r <= ST_FULL;
              OP_INSERT: st_r <= ins_bad ? ST_INVALID : ST_FULL;
              default: st_r <= ST_INVALID;
            endcase
          end else begin
            unique case (mode_r)
              OP_PUSH_FRONT: begin
                mem[phys(head_r, rev_r, (CW+1)'(CAPACITY - 1))] <= val_r;
                head_r  <= phys(head_r, rev_r, (CW+1)'(CAPACITY - 1));
                count_r <= count_r + 1'b1;
              end
              OP_PUSH_BACK: begin
                mem[phys(head_r, rev_r, (CW+1)'(count_r))] <= val_r;
                count_r <= count_r + 1'b1;
              end
              OP_POP_FRONT: begin
                vout_r  <= 32'(mem[head_r]);
                head_r  <= phys(head_r, rev_r, (CW+1)'(1));
                count_r <= count_r - 1'b1;
              end
              OP_POP_BACK: begin
                vout_r  <= 32'(mem[back_a]);
                count_r <= count_r - 1'b1;
              end
              OP_CLEAR: begin
                count_r <= '0; head_r <= '0; rev_r <= 1'b0;
              end
              default: begin
                if (!empty) head_r <= back_a;
                rev_r <= ~rev_r;
              end
            endcase
          end
        end
        DC_RDSH: rd_r <= mem[src_a];
        DC_WRSH: begin
          mem[dst_a] <= rd_r;
          idx_r <= (mode_r == OP_INSERT) ? idx_r - 1'b1 : idx_r + 1'b1;
        end
        DC_FINAL: begin
          if (mode_r == OP_INSERT) begin
            mem[phys(head_r, rev_r, (CW+1)'(pos_r))] <= val_r;
            count_r <= count_r + 1'b1;
          end else begin
            count_r <= count_r - 1'b1;
          end
        end
        DC_RDFB: front_r <= empty ? '0 : 32'(mem[front_a]);
        DC_RDBK: back_r  <= empty ? '0 : 32'(mem[back_a]);
        default: ;
      endcase
    end
  end

  assign out_value_out   = vout_r;
  assign out_status      = st_r;
  assign out_length      = 7'(count_r);
  assign out_front_value = front_r;
  assign out_back_value  = back_r;

endmodule

// ----- src/pdq_checker.sv -----
// ----------------------------------------------------------------------------
// pdq_checker
// Port-level checks on the queue's transaction behavior.
// ----------------------------------------------------------------------------
module pdq_checker
  import pdq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [6:0]  out_length,
  input logic [31:0] out_value_out,
  input logic [31:0] out_front_value
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_length))
    else $error("result changed while stalled");

  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_value_out == '0 && out_length == '0)
    else $error("empty pop with data");

  a_zlen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_length == '0 |-> out_front_value == '0)
    else $error("front nonzero on empty queue");

endmodule

bind positional_deque_store_top pdq_checker u_pdq_checker (.*);
